FILE: hw/rtl/rgbhsv_pkg.sv
// Shared widths, constants and pipeline stage types for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int unsigned CH_W   = 8;   // input channel width
  localparam int unsigned HUE_W  = 9;   // hue output width
  localparam int unsigned PCT_W  = 7;   // percent output width
  localparam int unsigned QUOT_W = 7;   // quotient bits, one divider stage each
  localparam int unsigned REM_W  = 15;  // dividend / remainder width
  localparam int unsigned VAL_SHIFT = 8;
  // input stage, operand stage, QUOT_W divider stages, output register
  localparam int unsigned NUM_STAGES = QUOT_W + 3;

  localparam logic [REM_W-1:0] HUE_SCALE = REM_W'(60);
  localparam logic [REM_W-1:0] SAT_SCALE = REM_W'(100);
  localparam logic [REM_W-1:0] VAL_SCALE = REM_W'(101);

  localparam logic [HUE_W-1:0] HUE_GREEN   = HUE_W'(120);
  localparam logic [HUE_W-1:0] HUE_BLUE    = HUE_W'(240);
  localparam logic [HUE_W-1:0] HUE_FULL    = HUE_W'(360);
  localparam logic [HUE_W-1:0] HUE_RED_TOP = HUE_W'(350);
  localparam logic [HUE_W-1:0] HUE_ORANGE  = HUE_W'(40);
  localparam logic [HUE_W-1:0] HUE_YELLOW  = HUE_W'(60);
  localparam logic [HUE_W-1:0] HUE_LIFT    = HUE_W'(10);
  localparam logic [HUE_W-1:0] HUE_YBASE   = HUE_W'(50);
  localparam logic [PCT_W-1:0] PCT_MAX     = PCT_W'(100);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // after max/min search
  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] lo;
    sector_t         sector;
  } sort_t;

  // operands and partial results carried through the divider stages
  typedef struct packed {
    logic [REM_W-1:0]  rem_h;
    logic [REM_W-1:0]  rem_s;
    logic [CH_W-1:0]   den_h;
    logic [CH_W-1:0]   den_s;
    logic [QUOT_W-1:0] q_h;
    logic [QUOT_W-1:0] q_s;
    sector_t           sector;
    logic              neg;
    logic              gray;
    logic [PCT_W-1:0]  bright;
  } div_t;

endpackage

FILE: hw/rtl/rgbhsv_in_if.sv
// Input channel: one RGB pixel per beat.
interface rgbhsv_in_if;
  import rgbhsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/rgbhsv_out_if.sv
// Output channel: one HSV result per beat.
interface rgbhsv_out_if;
  import rgbhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

FILE: hw/rtl/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter: pipelined max/min sort, restoring dividers, hue assembly.
// One pixel is taken per cycle while the pipeline is not stalled; there are 10 register
// stages: sort, operand setup, 7 divider steps of one quotient bit each, output.
// Every stage holds when the stage ahead of it is full and stalled, and an empty
// stage is filled even while the output waits, so bubbles close up under backpressure.
// Gray pixels (all channels equal) give saturation 0 and hue 0 (HUE_LIFT when the
// hue_shift_enable bit is set). The hue_shift_enable bit is written through
// cfg_write_en/cfg_write_data and should only change while the pipeline is empty.
module rgb_to_hsv_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic               cfg_write_data,
  rgbhsv_in_if.sink          rgb,
  rgbhsv_out_if.source       hsv
);
  import rgbhsv_pkg::*;

  logic                  hue_shift_enable;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] ld;

  sort_t sort_q, sort_next;
  div_t  op_next;
  div_t  dv [QUOT_W+1];
  div_t  dv_next [QUOT_W+1];

  logic [HUE_W-1:0] hue_raw, hue_final, hue_q;
  logic [PCT_W-1:0] sat_final, sat_q, bright_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift_enable <= 1'b0;
    end else if (cfg_write_en) begin
      hue_shift_enable <= cfg_write_data;
    end
  end

  // A stage loads when it is empty or the stage ahead loads too.
  always_comb begin
    ld[NUM_STAGES-1] = !vld[NUM_STAGES-1] || hsv.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign rgb.ready = ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= rgb.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ld[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 1: max, min and the hue sector; ties go red, then green.
  always_comb begin
    sort_next.mx = rgb.red;
    sort_next.mn = rgb.red;
    if (rgb.green > sort_next.mx) sort_next.mx = rgb.green;
    if (rgb.blue > sort_next.mx) sort_next.mx = rgb.blue;
    if (rgb.green < sort_next.mn) sort_next.mn = rgb.green;
    if (rgb.blue < sort_next.mn) sort_next.mn = rgb.blue;
    priority if (rgb.red >= rgb.green && rgb.red >= rgb.blue) begin
      sort_next.sector = SEC_RED;
      sort_next.hi     = rgb.green;
      sort_next.lo     = rgb.blue;
    end else if (rgb.green >= rgb.blue) begin
      sort_next.sector = SEC_GREEN;
      sort_next.hi     = rgb.blue;
      sort_next.lo     = rgb.red;
    end else begin
      sort_next.sector = SEC_BLUE;
      sort_next.hi     = rgb.red;
      sort_next.lo     = rgb.green;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) sort_q <= sort_next;
  end

  // Stage 2: chroma, sign and magnitude of the hue numerator, scaled dividends, brightness.
  always_comb begin
    logic [CH_W-1:0]  chroma;
    logic [CH_W-1:0]  mag;
    logic [REM_W-1:0] val_prod;
    chroma   = sort_q.mx - sort_q.mn;
    mag      = (sort_q.hi < sort_q.lo) ? (sort_q.lo - sort_q.hi) : (sort_q.hi - sort_q.lo);
    val_prod = REM_W'(sort_q.mx) * VAL_SCALE;
    op_next.rem_h  = REM_W'(mag) * HUE_SCALE;
    op_next.rem_s  = REM_W'(chroma) * SAT_SCALE;
    op_next.den_h  = chroma;
    op_next.den_s  = sort_q.mx;
    op_next.q_h    = '0;
    op_next.q_s    = '0;
    op_next.sector = sort_q.sector;
    op_next.neg    = sort_q.hi < sort_q.lo;
    op_next.gray   = chroma == '0;
    op_next.bright = PCT_W'(val_prod >> VAL_SHIFT);
  end

  // Divider steps: stage i resolves quotient bit QUOT_W-i of both quotients.
  always_comb begin
    dv_next[0] = op_next;
    for (int i = 1; i <= QUOT_W; i++) begin
      logic [REM_W-1:0] trial_h;
      logic [REM_W-1:0] trial_s;
      trial_h = REM_W'(dv[i-1].den_h) << (QUOT_W - i);
      trial_s = REM_W'(dv[i-1].den_s) << (QUOT_W - i);
      dv_next[i] = dv[i-1];
      if (dv[i-1].rem_h >= trial_h) begin
        dv_next[i].rem_h = dv[i-1].rem_h - trial_h;
        dv_next[i].q_h[QUOT_W-i] = 1'b1;
      end
      if (dv[i-1].rem_s >= trial_s) begin
        dv_next[i].rem_s = dv[i-1].rem_s - trial_s;
        dv_next[i].q_s[QUOT_W-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= QUOT_W; i++) begin
      if (ld[i+1]) dv[i] <= dv_next[i];
    end
  end

  // Output stage: add the sector base, wrap negatives, optional spreading.
  always_comb begin
    logic [HUE_W-1:0] qh;
    logic [HUE_W:0]   dbl;
    qh = HUE_W'(dv[QUOT_W].q_h);
    unique case (dv[QUOT_W].sector)
      SEC_RED:   hue_raw = (dv[QUOT_W].neg && qh != '0) ? (HUE_FULL - qh) : qh;
      SEC_GREEN: hue_raw = dv[QUOT_W].neg ? (HUE_GREEN - qh) : (HUE_GREEN + qh);
      SEC_BLUE:  hue_raw = dv[QUOT_W].neg ? (HUE_BLUE - qh) : (HUE_BLUE + qh);
      default:   hue_raw = '0;
    endcase
    if (dv[QUOT_W].gray) hue_raw = '0;

    dbl       = {hue_raw, 1'b0} - {1'b0, HUE_RED_TOP};
    hue_final = hue_raw;
    if (hue_shift_enable) begin
      priority if (hue_raw >= HUE_RED_TOP) begin
        hue_final = (dbl >= {1'b0, HUE_FULL}) ? HUE_W'(dbl - {1'b0, HUE_FULL}) : HUE_W'(dbl);
      end else if (hue_raw < HUE_ORANGE) begin
        hue_final = hue_raw + HUE_LIFT;
      end else if (hue_raw < HUE_YELLOW) begin
        hue_final = HUE_YBASE + ((hue_raw - HUE_ORANGE) >> 1);
      end else begin
        hue_final = hue_raw;
      end
    end

    sat_final = dv[QUOT_W].gray ? '0 : PCT_W'(dv[QUOT_W].q_s);
  end

  always_ff @(posedge clk) begin
    if (ld[NUM_STAGES-1]) begin
      hue_q    <= hue_final;
      sat_q    <= sat_final;
      bright_q <= dv[QUOT_W].bright;
    end
  end

  assign hsv.valid      = vld[NUM_STAGES-1];
  assign hsv.hue        = hue_q;
  assign hsv.saturation = sat_q;
  assign hsv.brightness = bright_q;

endmodule

FILE: hw/rtl/rgbhsv_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rgbhsv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rgbhsv_pkg::HUE_W-1:0] hue,
  input logic [rgbhsv_pkg::PCT_W-1:0] saturation,
  input logic [rgbhsv_pkg::PCT_W-1:0] brightness
);
  import rgbhsv_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled output beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hue) && $stable(saturation) && $stable(brightness))
    else $error("stalled output beat changed");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < HUE_FULL)
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> saturation <= PCT_MAX && brightness <= PCT_MAX)
    else $error("percent output out of range");

endmodule

bind rgb_to_hsv_converter_unit rgbhsv_checker u_rgbhsv_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (hsv.valid),
  .out_ready  (hsv.ready),
  .hue        (hsv.hue),
  .saturation (hsv.saturation),
  .brightness (hsv.brightness)
);
